// ----- rtl/core/smii_pkg.sv -----
// smii_pkg: shared types and constants for the strided multidimensional
// index iterator. No dependencies.
package smii_pkg;

  localparam int MAX_DIMS = 4;
  localparam int DIM_W    = 16;
  localparam int COORD_W  = 33;
  localparam int CARRY_W  = 20;   // holds digit plus carry over four dimensions
  localparam int DIV_CNT  = CARRY_W;
  localparam int CNT_W    = $clog2(DIV_CNT);
  localparam int IDX_W    = $clog2(MAX_DIMS);
  localparam int NDIM_W   = $clog2(MAX_DIMS + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMS_USED = 3'd0,
    CFG_EXTENTS   = 3'd1,
    CFG_STARTS    = 3'd2,
    CFG_STEPS     = 3'd3,
    CFG_STRIDE    = 3'd4,
    CFG_OFFSET    = 3'd5
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

// ----- rtl/core/strided_multidim_index_iterator.sv -----
// strided_multidim_index_iterator: mixed-radix index counter with strided
// coordinate output. Depends on smii_pkg.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | in_restart
//  out     | output    | out_valid / out_stall | out_valid_res, out_coord_0..3, out_last
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item at a time. The carry walk visits up to four dimensions, each one
// a setup step and then a restoring divide of digit plus carry by the
// extent; the coordinates are formed lane by lane on one shared 16x17
// multiplier. A restart item can walk twice, first adding the offset and,
// after the coordinates, the stride. A plain item on an exhausted iterator goes straight to the output.
// Reset (rst_n low, synchronous) leaves the iterator exhausted with all
// digits zero; config takes its reset values.
// in_stall is high while an item is in progress. The result sits in an
// output register; a stalled result holds the block at the end of the next item.
// cfg_ready is always high; config writes never touch the index.
module strided_multidim_index_iterator (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_restart,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_valid_res,
  output logic signed [smii_pkg::COORD_W-1:0]    out_coord_0,
  output logic signed [smii_pkg::COORD_W-1:0]    out_coord_1,
  output logic signed [smii_pkg::COORD_W-1:0]    out_coord_2,
  output logic signed [smii_pkg::COORD_W-1:0]    out_coord_3,
  output logic                                   out_last,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [smii_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [smii_pkg::CFG_DAT_W-1:0]         cfg_data
);

  localparam int DW = smii_pkg::DIM_W;
  localparam int CW = smii_pkg::CARRY_W;
  localparam int OW = smii_pkg::COORD_W;

  // config registers
  logic [2:0]     dims_r;
  logic [63:0]    ext_r, start_r, step_r;
  logic [DW-1:0]  stride_r, offset_r;

  // sequencer and datapath state
  smii_pkg::state_t state_r, state_nxt;
  logic [DW-1:0]  digit_r [smii_pkg::MAX_DIMS];
  logic [DW-1:0]  digit_nxt [smii_pkg::MAX_DIMS];
  logic           exh_r, exh_nxt;
  logic           phase_r, phase_nxt;      // 0: restart walk, 1: advance walk
  logic           zext_r, zext_nxt;
  logic [smii_pkg::NDIM_W-1:0] dim_r, dim_nxt;  // walk position, counts down
  logic [smii_pkg::IDX_W-1:0]  k_r, k_nxt;      // coordinate lane
  logic [CW-1:0]  carry_r, carry_nxt;
  logic [CW-1:0]  divq_r, divq_nxt;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [smii_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic           last_r, last_nxt;
  logic signed [OW-1:0] coord_r [smii_pkg::MAX_DIMS];
  logic signed [OW-1:0] coord_nxt [smii_pkg::MAX_DIMS];

  // output register
  logic           ov_r, ov_nxt;
  logic           ovres_r, ovres_nxt;
  logic           olast_r, olast_nxt;
  logic signed [OW-1:0] ocoord_r [smii_pkg::MAX_DIMS];
  logic signed [OW-1:0] ocoord_nxt [smii_pkg::MAX_DIMS];

  logic [smii_pkg::NDIM_W-1:0] n_act;
  logic           zext_now;
  logic [smii_pkg::IDX_W-1:0]  widx;
  logic [DW-1:0]  wext;
  logic [DW:0]    rem_s;
  logic           qbit;
  logic signed [OW-1:0] prod;
  logic           out_free;

  always_comb begin
    if (dims_r > 3'(smii_pkg::MAX_DIMS)) n_act = smii_pkg::NDIM_W'(smii_pkg::MAX_DIMS);
    else n_act = smii_pkg::NDIM_W'(dims_r);
  end

  always_comb begin
    zext_now = 1'b0;
    for (int d = 0; d < smii_pkg::MAX_DIMS; d++) begin
      if ((smii_pkg::NDIM_W'(d) < n_act) && (ext_r[16*d +: 16] == 16'd0)) zext_now = 1'b1;
    end
  end

  // dimension the walk would step into next
  assign widx = smii_pkg::IDX_W'(dim_r - smii_pkg::NDIM_W'(1));
  assign wext = ext_r[16*widx +: 16];

  // one restoring divide step
  assign rem_s = {rem_r, divq_r[CW-1]};
  assign qbit  = (rem_s >= {1'b0, wext});

  // shared multiplier: start + step * digit for lane k
  assign prod = OW'($signed(start_r[16*k_r +: 16]))
              + OW'($signed(step_r[16*k_r +: 16]) * $signed({1'b0, digit_r[k_r]}));

  assign out_free  = !ov_r || !out_stall;
  assign in_stall  = (state_r != smii_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    exh_nxt   = exh_r;
    phase_nxt = phase_r;
    zext_nxt  = zext_r;
    dim_nxt   = dim_r;
    k_nxt     = k_r;
    carry_nxt = carry_r;
    divq_nxt  = divq_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    ov_nxt    = ov_r;
    ovres_nxt = ovres_r;
    olast_nxt = olast_r;
    for (int d = 0; d < smii_pkg::MAX_DIMS; d++) begin
      digit_nxt[d]  = digit_r[d];
      coord_nxt[d]  = coord_r[d];
      ocoord_nxt[d] = ocoord_r[d];
    end
    if (ov_r && !out_stall) ov_nxt = 1'b0;

    case (state_r)
      smii_pkg::S_IDLE: begin
        if (in_valid) begin
          last_nxt = 1'b0;
          for (int d = 0; d < smii_pkg::MAX_DIMS; d++) coord_nxt[d] = '0;
          if (in_restart) begin
            for (int d = 0; d < smii_pkg::MAX_DIMS; d++) digit_nxt[d] = '0;
            zext_nxt  = zext_now;
            carry_nxt = CW'(offset_r);
            dim_nxt   = n_act;
            phase_nxt = 1'b0;
            state_nxt = smii_pkg::S_WALK;
          end else if (exh_r) begin
            // no tuple: mark the item as not advanced
            phase_nxt = 1'b0;
            state_nxt = smii_pkg::S_OUT;
          end else begin
            k_nxt     = '0;
            state_nxt = smii_pkg::S_MUL;
          end
        end
      end
      smii_pkg::S_WALK: begin
        if ((carry_r == '0) || (dim_r == '0) || (wext == '0)) begin
          // walk done; carry out if any carry is left or a zero extent was hit
          if (!phase_r) begin
            exh_nxt = zext_r || (carry_r != '0);
            if (zext_r || (carry_r != '0)) state_nxt = smii_pkg::S_OUT;
            else begin
              k_nxt     = '0;
              state_nxt = smii_pkg::S_MUL;
            end
          end else begin
            last_nxt  = (carry_r != '0);
            if (carry_r != '0) exh_nxt = 1'b1;
            state_nxt = smii_pkg::S_OUT;
          end
        end else begin
          divq_nxt  = CW'(digit_r[widx]) + carry_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = smii_pkg::S_DIV;
        end
      end
      smii_pkg::S_DIV: begin
        rem_nxt  = qbit ? DW'(rem_s - {1'b0, wext}) : rem_s[DW-1:0];
        divq_nxt = {divq_r[CW-2:0], qbit};
        cnt_nxt  = cnt_r + smii_pkg::CNT_W'(1);
        if (cnt_r == smii_pkg::CNT_W'(smii_pkg::DIV_CNT - 1)) begin
          digit_nxt[widx] = qbit ? DW'(rem_s - {1'b0, wext}) : rem_s[DW-1:0];
          carry_nxt = {divq_r[CW-2:0], qbit};
          dim_nxt   = dim_r - smii_pkg::NDIM_W'(1);
          state_nxt = smii_pkg::S_WALK;
        end
      end
      smii_pkg::S_MUL: begin
        // inactive lanes stay zero
        if (smii_pkg::NDIM_W'(k_r) < n_act) coord_nxt[k_r] = prod;
        k_nxt = k_r + smii_pkg::IDX_W'(1);
        if (k_r == smii_pkg::IDX_W'(smii_pkg::MAX_DIMS - 1)) begin
          carry_nxt = CW'(stride_r);
          dim_nxt   = n_act;
          phase_nxt = 1'b1;
          state_nxt = smii_pkg::S_WALK;
        end
      end
      smii_pkg::S_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ovres_nxt = !exh_r || phase_r;
          olast_nxt = last_r;
          for (int d = 0; d < smii_pkg::MAX_DIMS; d++) begin
            ocoord_nxt[d] = (!exh_r || phase_r) ? coord_r[d] : '0;
          end
          state_nxt = smii_pkg::S_IDLE;
        end
      end
      default: state_nxt = smii_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= smii_pkg::S_IDLE;
      exh_r    <= 1'b1;
      ov_r     <= 1'b0;
      for (int d = 0; d < smii_pkg::MAX_DIMS; d++) digit_r[d] <= '0;
      dims_r   <= 3'd1;
      ext_r    <= '0;
      start_r  <= '0;
      step_r   <= '0;
      stride_r <= DW'(1);
      offset_r <= '0;
    end else begin
      state_r <= state_nxt;
      exh_r   <= exh_nxt;
      ov_r    <= ov_nxt;
      for (int d = 0; d < smii_pkg::MAX_DIMS; d++) digit_r[d] <= digit_nxt[d];
      if (cfg_valid) begin
        case (cfg_index)
          smii_pkg::CFG_DIMS_USED: dims_r   <= cfg_data[2:0];
          smii_pkg::CFG_EXTENTS:   ext_r    <= cfg_data;
          smii_pkg::CFG_STARTS:    start_r  <= cfg_data;
          smii_pkg::CFG_STEPS:     step_r   <= cfg_data;
          smii_pkg::CFG_STRIDE:    stride_r <= cfg_data[DW-1:0];
          smii_pkg::CFG_OFFSET:    offset_r <= cfg_data[DW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    zext_r  <= zext_nxt;
    dim_r   <= dim_nxt;
    k_r     <= k_nxt;
    carry_r <= carry_nxt;
    divq_r  <= divq_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    last_r  <= last_nxt;
    ovres_r <= ovres_nxt;
    olast_r <= olast_nxt;
    for (int d = 0; d < smii_pkg::MAX_DIMS; d++) begin
      coord_r[d]  <= coord_nxt[d];
      ocoord_r[d] <= ocoord_nxt[d];
    end
  end

  assign out_valid     = ov_r;
  assign out_valid_res = ovres_r;
  assign out_last      = olast_r;
  assign out_coord_0   = ocoord_r[0];
  assign out_coord_1   = ocoord_r[1];
  assign out_coord_2   = ocoord_r[2];
  assign out_coord_3   = ocoord_r[3];

endmodule

// ----- rtl/core/smii_checker.sv -----
// smii_port_props: port-level assertions for the index iterator, bound to the
// top level. Depends on smii_pkg.
module smii_port_props (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                out_valid_res,
  input logic signed [smii_pkg::COORD_W-1:0] out_coord_0,
  input logic signed [smii_pkg::COORD_W-1:0] out_coord_1,
  input logic signed [smii_pkg::COORD_W-1:0] out_coord_2,
  input logic signed [smii_pkg::COORD_W-1:0] out_coord_3,
  input logic                                out_last
);

  // a held result keeps its last flag and its first coordinate
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_last) && $stable(out_coord_0))
    else $error("result changed under stall");

  // an exhausted result carries no coordinates
  a_exh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> !out_last && out_coord_0 == '0 && out_coord_1 == '0
      && out_coord_2 == '0 && out_coord_3 == '0)
    else $error("exhausted result with payload");

  // last only on a meaningful tuple
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_valid_res)
    else $error("last without valid tuple");

  // an accepted item makes the input busy in the following cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

endmodule

bind strided_multidim_index_iterator smii_port_props u_smii_port_props (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_valid_res(out_valid_res),
  .out_coord_0(out_coord_0), .out_coord_1(out_coord_1), .out_coord_2(out_coord_2),
  .out_coord_3(out_coord_3), .out_last(out_last)
);
